// ===== rtl/movdec_pkg.sv =====
// ----------------------------------------------------------------------------
// movdec_pkg
// Types, opcode constants and small decode helpers shared by the MOV
// instruction byte decoder, its result channel interface and its checker.
// ----------------------------------------------------------------------------
`default_nettype none

package movdec_pkg;

    // result status codes
    typedef enum logic [1:0] {
        STATUS_DONE       = 2'd0,
        STATUS_BAD_OPCODE = 2'd1,
        STATUS_TRUNCATED  = 2'd2
    } t_status;

    // instruction forms; FORM_NONE marks an opcode outside the MOV subset
    typedef enum logic [2:0] {
        FORM_RMREG  = 3'd0,
        FORM_IMMRM  = 3'd1,
        FORM_IMMREG = 3'd2,
        FORM_MEMACC = 3'd3,
        FORM_ACCMEM = 3'd4,
        FORM_NONE   = 3'd7
    } t_form;

    // opcode prefixes, compared against the upper opcode bits
    localparam logic [5:0] OP_RMREG_TOP  = 6'h22;  // 100010dw
    localparam logic [6:0] OP_IMMRM_TOP  = 7'h63;  // 1100011w
    localparam logic [3:0] OP_IMMREG_TOP = 4'hB;   // 1011wrrr
    localparam logic [6:0] OP_MEMACC_TOP = 7'h50;  // 1010000w
    localparam logic [6:0] OP_ACCMEM_TOP = 7'h51;  // 1010001w

    // mod-reg-rm field codes
    localparam logic [2:0] RM_DIRECT = 3'd6;
    localparam logic [1:0] MOD_MEM0  = 2'd0;
    localparam logic [1:0] MOD_DISP8 = 2'd1;
    localparam logic [1:0] MOD_DISP16 = 2'd2;
    localparam logic [1:0] MOD_REG   = 2'd3;

    // one decoded result
    typedef struct packed {
        t_status            status;
        t_form              form;
        logic               wide;
        logic               to_register;
        logic [1:0]         mode;
        logic [2:0]         reg_index;
        logic [2:0]         rm_index;
        logic               direct_address;
        logic signed [15:0] displacement;
        logic signed [15:0] immediate;
        logic [2:0]         length;
    } t_result;

    // form of an opcode byte
    function automatic t_form classify(input logic [7:0] op);
        t_form f;
        if (op[7:2] == OP_RMREG_TOP)       f = FORM_RMREG;
        else if (op[7:1] == OP_IMMRM_TOP)  f = FORM_IMMRM;
        else if (op[7:4] == OP_IMMREG_TOP) f = FORM_IMMREG;
        else if (op[7:1] == OP_MEMACC_TOP) f = FORM_MEMACC;
        else if (op[7:1] == OP_ACCMEM_TOP) f = FORM_ACCMEM;
        else                               f = FORM_NONE;
        return f;
    endfunction

    // w bit sits at bit 3 for immediate to register, bit 0 elsewhere
    function automatic logic wide_bit(input t_form f, input logic [7:0] op);
        return (f == FORM_IMMREG) ? op[3] : op[0];
    endfunction

    // displacement bytes called for by a mod-reg-rm byte
    function automatic logic [1:0] disp_len(input logic [7:0] modrm);
        logic [1:0] n;
        if (modrm[7:6] == MOD_MEM0 && modrm[2:0] == RM_DIRECT) n = 2'd2;
        else if (modrm[7:6] == MOD_DISP8)                      n = 2'd1;
        else if (modrm[7:6] == MOD_DISP16)                     n = 2'd2;
        else                                                   n = 2'd0;
        return n;
    endfunction

    // byte to word with sign extension
    function automatic logic [15:0] sext8(input logic [7:0] b);
        return {{8{b[7]}}, b};
    endfunction

endpackage

`default_nettype wire

// ===== rtl/movdec_in_if.sv =====
// ----------------------------------------------------------------------------
// movdec_in_if
// Byte stream channel: one code byte and its end-of-stream flag per
// transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface movdec_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] code_byte;
    logic       stream_end;

    modport source (output valid, output code_byte, output stream_end, input ready);
    modport sink   (input valid, input code_byte, input stream_end, output ready);
endinterface

`default_nettype wire

// ===== rtl/movdec_out_if.sv =====
// ----------------------------------------------------------------------------
// movdec_out_if
// Result channel: one decoded instruction or error report per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface movdec_out_if;
    import movdec_pkg::*;

    logic               valid;
    logic               ready;
    t_status            status;
    t_form              form;
    logic               wide;
    logic               to_register;
    logic [1:0]         mode;
    logic [2:0]         reg_index;
    logic [2:0]         rm_index;
    logic               direct_address;
    logic signed [15:0] displacement;
    logic signed [15:0] immediate;
    logic [2:0]         length;

    modport source (
        output valid, input ready,
        output status, output form, output wide, output to_register, output mode,
        output reg_index, output rm_index, output direct_address,
        output displacement, output immediate, output length
    );
    modport sink (
        input valid, output ready,
        input status, input form, input wide, input to_register, input mode,
        input reg_index, input rm_index, input direct_address,
        input displacement, input immediate, input length
    );
endinterface

`default_nettype wire

// ===== rtl/mov_instruction_byte_decoder.sv =====
// Output: a result is registered from the transaction that carries the last
//   byte of its instruction (or the byte that causes the error).
// Throughput: one code byte per cycle while the skid stage is empty; the
//   output register and one-entry skid stage let bytes flow while a result waits.
// Reset: synchronous, active low; decoder returns to opcode fetch, clears the
//   halt flag and empties both output stages.
// ----------------------------------------------------------------------------
// mov_instruction_byte_decoder
// Decodes the 8086 MOV subset byte by byte and reports each instruction.
// ----------------------------------------------------------------------------
`default_nettype none

module mov_instruction_byte_decoder (
    input  wire             i_clk,
    input  wire             i_rst_n,
    movdec_in_if.sink       i_in,
    movdec_out_if.source    o_out
);
    import movdec_pkg::*;

    typedef enum logic [2:0] {
        PH_OPCODE = 3'd0,
        PH_MODRM  = 3'd1,
        PH_DISPLO = 3'd2,
        PH_DISPHI = 3'd3,
        PH_IMMLO  = 3'd4,
        PH_IMMHI  = 3'd5
    } t_phase;

    // decoder state
    t_phase      r_phase, n_phase;
    logic [7:0]  r_opcode, n_opcode;
    logic [7:0]  r_modrm, n_modrm;
    logic [15:0] r_disp, n_disp;
    logic [15:0] r_imm, n_imm;
    logic [2:0]  r_bytes, n_bytes;
    logic        r_halted;

    // output register and skid stage
    logic        r_out_valid;
    t_result     r_out;
    logic        r_skid_valid;
    t_result     r_skid;

    logic        w_accept;
    logic        w_step;
    logic        w_done;
    logic        w_bad_op;
    logic        w_has_result;
    logic [2:0]  w_bytes_inc;
    t_form       w_cur_form;
    t_form       w_fin_form;
    t_result     w_res;

    wire [7:0] w_b   = i_in.code_byte;
    wire       w_end = i_in.stream_end;

    assign i_in.ready = !r_skid_valid;
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_step     = w_accept && !r_halted;

    // phase update for one byte
    always_comb begin
        n_phase     = r_phase;
        n_opcode    = r_opcode;
        n_modrm     = r_modrm;
        n_disp      = r_disp;
        n_imm       = r_imm;
        w_done      = 1'b0;
        w_bad_op    = 1'b0;
        w_cur_form  = classify(r_opcode);
        w_bytes_inc = (r_bytes != 3'd7) ? r_bytes + 3'd1 : r_bytes;
        n_bytes     = w_bytes_inc;
        unique case (r_phase)
            PH_MODRM: begin
                n_modrm = w_b;
                if (disp_len(w_b) != 2'd0)       n_phase = PH_DISPLO;
                else if (w_cur_form == FORM_IMMRM) n_phase = PH_IMMLO;
                else                             w_done  = 1'b1;
            end
            PH_DISPLO: begin
                if (w_cur_form == FORM_MEMACC || w_cur_form == FORM_ACCMEM ||
                    disp_len(r_modrm) == 2'd2) begin
                    n_disp  = {8'h00, w_b};
                    n_phase = PH_DISPHI;
                end else begin
                    n_disp = sext8(w_b);
                    if (w_cur_form == FORM_IMMRM) n_phase = PH_IMMLO;
                    else                          w_done  = 1'b1;
                end
            end
            PH_DISPHI: begin
                n_disp = {w_b, r_disp[7:0]};
                if (w_cur_form == FORM_IMMRM) n_phase = PH_IMMLO;
                else                          w_done  = 1'b1;
            end
            PH_IMMLO: begin
                if (wide_bit(w_cur_form, r_opcode)) begin
                    n_imm   = {8'h00, w_b};
                    n_phase = PH_IMMHI;
                end else begin
                    n_imm  = sext8(w_b);
                    w_done = 1'b1;
                end
            end
            PH_IMMHI: begin
                n_imm  = {w_b, r_imm[7:0]};
                w_done = 1'b1;
            end
            default: begin
                // opcode fetch starts a new instruction
                n_opcode = w_b;
                n_modrm  = 8'h00;
                n_disp   = 16'h0000;
                n_imm    = 16'h0000;
                n_bytes  = 3'd1;
                case (classify(w_b))
                    FORM_RMREG, FORM_IMMRM: n_phase  = PH_MODRM;
                    FORM_IMMREG:            n_phase  = PH_IMMLO;
                    FORM_MEMACC, FORM_ACCMEM: n_phase = PH_DISPLO;
                    default:                w_bad_op = 1'b1;
                endcase
            end
        endcase
        w_has_result = w_bad_op || w_done || w_end;
    end

    // result assembly from the updated instruction fields
    always_comb begin
        w_fin_form = classify(n_opcode);
        w_res      = '0;
        w_res.length = n_bytes;
        if (w_bad_op) begin
            w_res.status = STATUS_BAD_OPCODE;
        end else if (w_done) begin
            w_res.status = STATUS_DONE;
            w_res.form   = w_fin_form;
            w_res.wide   = wide_bit(w_fin_form, n_opcode);
            case (w_fin_form)
                FORM_RMREG, FORM_IMMRM: begin
                    w_res.to_register    = (w_fin_form == FORM_RMREG) ? n_opcode[1] : 1'b0;
                    w_res.mode           = n_modrm[7:6];
                    w_res.reg_index      = (w_fin_form == FORM_RMREG) ? n_modrm[5:3] : 3'd0;
                    w_res.rm_index       = n_modrm[2:0];
                    w_res.direct_address = (n_modrm[7:6] == MOD_MEM0) &&
                                           (n_modrm[2:0] == RM_DIRECT);
                    w_res.displacement   = (disp_len(n_modrm) != 2'd0) ?
                                           $signed(n_disp) : 16'sd0;
                    w_res.immediate      = (w_fin_form == FORM_IMMRM) ?
                                           $signed(n_imm) : 16'sd0;
                end
                FORM_IMMREG: begin
                    w_res.to_register = 1'b1;
                    w_res.mode        = MOD_REG;
                    w_res.reg_index   = n_opcode[2:0];
                    w_res.immediate   = $signed(n_imm);
                end
                default: begin
                    // accumulator forms
                    w_res.to_register    = (w_fin_form == FORM_MEMACC);
                    w_res.rm_index       = RM_DIRECT;
                    w_res.direct_address = 1'b1;
                    w_res.displacement   = $signed(n_disp);
                end
            endcase
        end else begin
            w_res.status = STATUS_TRUNCATED;
        end
    end

    // state, halt flag and output stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_OPCODE;
            r_halted     <= 1'b0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (w_step) begin
                r_opcode <= n_opcode;
                r_modrm  <= n_modrm;
                r_disp   <= n_disp;
                r_imm    <= n_imm;
                r_bytes  <= n_bytes;
                if (w_has_result) begin
                    r_phase <= PH_OPCODE;
                    if (!w_done) r_halted <= 1'b1;
                end else begin
                    r_phase <= n_phase;
                end
            end

            // new result loads the main stage when it is free or draining,
            // otherwise a drained main stage refills from skid or goes empty
            if (w_step && w_has_result && (!r_out_valid || o_out.ready)) begin
                r_out       <= w_res;
                r_out_valid <= 1'b1;
            end else if (r_out_valid && o_out.ready) begin
                if (r_skid_valid) begin
                    r_out        <= r_skid;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out_valid <= 1'b0;
                end
            end

            // new result behind a stalled main stage waits in skid
            if (w_step && w_has_result && r_out_valid && !o_out.ready) begin
                r_skid       <= w_res;
                r_skid_valid <= 1'b1;
            end
        end
    end

    // result channel
    assign o_out.valid          = r_out_valid;
    assign o_out.status         = r_out.status;
    assign o_out.form           = r_out.form;
    assign o_out.wide           = r_out.wide;
    assign o_out.to_register    = r_out.to_register;
    assign o_out.mode           = r_out.mode;
    assign o_out.reg_index      = r_out.reg_index;
    assign o_out.rm_index       = r_out.rm_index;
    assign o_out.direct_address = r_out.direct_address;
    assign o_out.displacement   = r_out.displacement;
    assign o_out.immediate      = r_out.immediate;
    assign o_out.length         = r_out.length;

endmodule

`default_nettype wire

// ===== rtl/movdec_checker.sv =====
// ----------------------------------------------------------------------------
// movdec_checker
// Port-level checks on the MOV decoder channels, bound into the decoder module.
// ----------------------------------------------------------------------------
`default_nettype none

module movdec_checker (
    input wire                   i_clk,
    input wire                   i_rst_n,
    input wire                   i_in_valid,
    input wire                   i_in_ready,
    input wire                   i_out_valid,
    input wire                   i_out_ready,
    input movdec_pkg::t_status   i_out_status,
    input wire [2:0]             i_out_length,
    input wire signed [15:0]     i_out_immediate
);
    import movdec_pkg::*;

    // a stalled result stays offered
    a_out_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result valid dropped while stalled");

    // a stalled result keeps its status, length and immediate
    a_out_payload_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_status) && $stable(i_out_length)
            && $stable(i_out_immediate))
        else $error("result payload changed while stalled");

    // input back-pressure only while a result is pending
    a_stall_needs_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !i_in_ready |-> i_out_valid)
        else $error("input stalled with no result waiting");

    // an error report is the last result until reset
    a_error_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && i_out_status != STATUS_DONE |=> !i_out_valid)
        else $error("result delivered after an error report");

endmodule

bind mov_instruction_byte_decoder movdec_checker u_movdec_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in.valid),
    .i_in_ready      (i_in.ready),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_out_status    (o_out.status),
    .i_out_length    (o_out.length),
    .i_out_immediate (o_out.immediate)
);

`default_nettype wire

// ===== tb/sv/movdec_tb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// movdec_tb_pkg
// Scoreboard for the MOV byte decoder: it tracks the instruction being
// fetched and queues the decode or error report that each code byte completes.
// ----------------------------------------------------------------------------

package movdec_tb_pkg;
    import movdec_pkg::*;

    // fetch position inside the current instruction
    typedef enum logic [2:0] {
        FETCH_OPCODE,
        FETCH_MODRM,
        FETCH_DISP_LO,
        FETCH_DISP_HI,
        FETCH_IMM_LO,
        FETCH_IMM_HI
    } t_fetch;

    class movdec_scoreboard;
        t_fetch      fetch;
        logic [7:0]  opcode;
        logic [7:0]  modrm;
        logic [15:0] disp;
        logic [15:0] imm;
        logic [2:0]  taken;
        bit          halted;
        t_result     pending_decodes[$];
        int unsigned error_count;

        function new();
            fetch       = FETCH_OPCODE;
            opcode      = '0;
            modrm       = '0;
            disp        = '0;
            imm         = '0;
            taken       = '0;
            halted      = 1'b0;
            error_count = 0;
        endfunction

        // opcode patterns of the five supported MOV forms
        static function t_form form_of(logic [7:0] op);
            t_form f;
            casez (op)
                8'b1000_10??: f = FORM_RMREG;
                8'b1100_011?: f = FORM_IMMRM;
                8'b1011_????: f = FORM_IMMREG;
                8'b1010_000?: f = FORM_MEMACC;
                8'b1010_001?: f = FORM_ACCMEM;
                default:      f = FORM_NONE;
            endcase
            return f;
        endfunction

        // displacement bytes that follow a mod-reg-rm byte
        static function int unsigned disp_bytes(logic [7:0] m);
            int unsigned n;
            case (m[7:6])
                MOD_MEM0:   n = (m[2:0] == RM_DIRECT) ? 2 : 0;
                MOD_DISP8:  n = 1;
                MOD_DISP16: n = 2;
                default:    n = 0;
            endcase
            return n;
        endfunction

        function logic word_op(t_form f);
            return (f == FORM_IMMREG) ? opcode[3] : opcode[0];
        endfunction

        function t_fetch after_disp(t_form f);
            return (f == FORM_IMMRM) ? FETCH_IMM_LO : FETCH_OPCODE;
        endfunction

        function t_result failure(t_status s);
            t_result r;
            r        = '0;
            r.status = s;
            r.length = taken;
            return r;
        endfunction

        // fields of a completed instruction
        function t_result decoded();
            t_result r;
            t_form   f;
            r        = '0;
            f        = form_of(opcode);
            r.status = STATUS_DONE;
            r.form   = f;
            r.wide   = word_op(f);
            r.length = taken;
            case (f)
                FORM_RMREG, FORM_IMMRM: begin
                    r.to_register    = (f == FORM_RMREG) ? opcode[1] : 1'b0;
                    r.mode           = modrm[7:6];
                    r.reg_index      = (f == FORM_RMREG) ? modrm[5:3] : 3'd0;
                    r.rm_index       = modrm[2:0];
                    r.direct_address = (modrm[7:6] == MOD_MEM0) && (modrm[2:0] == RM_DIRECT);
                    r.displacement   = (disp_bytes(modrm) != 0) ? disp : 16'd0;
                    r.immediate      = (f == FORM_IMMRM) ? imm : 16'd0;
                end
                FORM_IMMREG: begin
                    r.to_register = 1'b1;
                    r.mode        = MOD_REG;
                    r.reg_index   = opcode[2:0];
                    r.immediate   = imm;
                end
                default: begin
                    r.to_register    = (f == FORM_MEMACC);
                    r.rm_index       = RM_DIRECT;
                    r.direct_address = 1'b1;
                    r.displacement   = disp;
                end
            endcase
            return r;
        endfunction

        // advance the fetch on one accepted code byte
        function void take_code_byte(logic [7:0] b, logic last);
            t_form  f;
            t_fetch nxt;
            if (halted) return;
            if (fetch == FETCH_OPCODE) begin
                opcode = b;
                modrm  = '0;
                disp   = '0;
                imm    = '0;
                taken  = 3'd1;
                f      = form_of(b);
                // unknown opcode locks the decoder
                if (f == FORM_NONE) begin
                    pending_decodes.push_back(failure(STATUS_BAD_OPCODE));
                    halted = 1'b1;
                    return;
                end
                case (f)
                    FORM_RMREG, FORM_IMMRM: nxt = FETCH_MODRM;
                    FORM_IMMREG:            nxt = FETCH_IMM_LO;
                    default:                nxt = FETCH_DISP_LO;
                endcase
            end else begin
                taken = taken + 3'd1;
                f     = form_of(opcode);
                case (fetch)
                    FETCH_MODRM: begin
                        modrm = b;
                        nxt   = (disp_bytes(b) != 0) ? FETCH_DISP_LO : after_disp(f);
                    end
                    FETCH_DISP_LO: begin
                        if (f == FORM_MEMACC || f == FORM_ACCMEM || disp_bytes(modrm) == 2) begin
                            disp = {8'h00, b};
                            nxt  = FETCH_DISP_HI;
                        end else begin
                            disp = {{8{b[7]}}, b};
                            nxt  = after_disp(f);
                        end
                    end
                    FETCH_DISP_HI: begin
                        disp[15:8] = b;
                        nxt        = after_disp(f);
                    end
                    FETCH_IMM_LO: begin
                        if (word_op(f)) begin
                            imm = {8'h00, b};
                            nxt = FETCH_IMM_HI;
                        end else begin
                            imm = {{8{b[7]}}, b};
                            nxt = FETCH_OPCODE;
                        end
                    end
                    default: begin
                        imm[15:8] = b;
                        nxt       = FETCH_OPCODE;
                    end
                endcase
            end
            if (nxt == FETCH_OPCODE) begin
                pending_decodes.push_back(decoded());
                fetch = FETCH_OPCODE;
            end else if (last) begin
                // stream ended inside the instruction
                pending_decodes.push_back(failure(STATUS_TRUNCATED));
                halted = 1'b1;
                fetch  = FETCH_OPCODE;
            end else begin
                fetch = nxt;
            end
        endfunction

        function int unsigned pending();
            return pending_decodes.size();
        endfunction

        function void field_ok(string name, logic [15:0] e, logic [15:0] a);
            if (e !== a) begin
                $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, e, a);
                error_count++;
            end
        endfunction

        // compare one output transaction with the oldest pending decode
        function void check_result(t_result act);
            t_result e;
            if (pending_decodes.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual status %0d form %0d len %0d",
                         $time, act.status, act.form, act.length);
                error_count++;
                return;
            end
            e = pending_decodes.pop_front();
            field_ok("status", e.status, act.status);
            field_ok("form", e.form, act.form);
            field_ok("wide", e.wide, act.wide);
            field_ok("to_register", e.to_register, act.to_register);
            field_ok("mode", e.mode, act.mode);
            field_ok("reg_index", e.reg_index, act.reg_index);
            field_ok("rm_index", e.rm_index, act.rm_index);
            field_ok("direct_address", e.direct_address, act.direct_address);
            field_ok("displacement", e.displacement, act.displacement);
            field_ok("immediate", e.immediate, act.immediate);
            field_ok("length", e.length, act.length);
        endfunction
    endclass

endpackage

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the MOV byte decoder with directed and random instruction streams,
// bursty input and a stalling result sink, and checks every report against
// the scoreboard. The run ends on a single error case, since an error locks
// the decoder until reset.
// ----------------------------------------------------------------------------

module tb_top;
    import movdec_pkg::*;
    import movdec_tb_pkg::*;

    typedef logic [7:0] t_bytes[$];

    localparam int unsigned RANDOM_BYTES  = 1150;
    localparam int unsigned STALL_LIMIT   = 2000;
    localparam int unsigned HOLD_CYCLES   = 300;
    localparam int unsigned DRAIN_CYCLES  = 8;
    localparam int unsigned PRESSURE_MOVS = 40;
    localparam int unsigned TAIL_BYTES    = 8;

    logic i_clk;
    logic i_rst_n;

    movdec_in_if  u_in();
    movdec_out_if u_out();

    mov_instruction_byte_decoder i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (u_in),
        .o_out   (u_out)
    );

    movdec_scoreboard sb;

    bit          hold_req;
    bit          no_gaps;
    int unsigned burst_left;
    int unsigned random_sent;

    initial sb = new();

    // clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // transaction monitor on both channels
    always @(posedge i_clk) begin
        t_result act;
        if (i_rst_n) begin
            if (u_out.valid && u_out.ready) begin
                act                = '0;
                act.status         = u_out.status;
                act.form           = u_out.form;
                act.wide           = u_out.wide;
                act.to_register    = u_out.to_register;
                act.mode           = u_out.mode;
                act.reg_index      = u_out.reg_index;
                act.rm_index       = u_out.rm_index;
                act.direct_address = u_out.direct_address;
                act.displacement   = u_out.displacement;
                act.immediate      = u_out.immediate;
                act.length         = u_out.length;
                sb.check_result(act);
            end
            if (u_in.valid && u_in.ready)
                sb.take_code_byte(u_in.code_byte, u_in.stream_end);
        end
    end

    // watchdog on cycles without any transaction
    initial begin
        int unsigned idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((u_in.valid && u_in.ready) || (u_out.valid && u_out.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // result sink stall patterns, plus one long hold-off on request
    initial begin
        int unsigned stretch;
        int unsigned pattern;
        int unsigned step;
        bit          hold_done;
        hold_done = 1'b0;
        u_out.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_req && !hold_done) begin
                repeat (HOLD_CYCLES) begin
                    u_out.ready <= 1'b0;
                    @(posedge i_clk);
                end
                hold_done = 1'b1;
            end else begin
                pattern = $urandom_range(0, 3);
                stretch = $urandom_range(1, 40);
                for (step = 0; step < stretch; step++) begin
                    case (pattern)
                        0:       u_out.ready <= 1'b1;
                        1:       u_out.ready <= 1'($urandom_range(0, 1));
                        2:       u_out.ready <= ($urandom_range(0, 3) == 0);
                        default: u_out.ready <= (step % 3 != 0);
                    endcase
                    @(posedge i_clk);
                end
            end
        end
    end

    // offer one code byte, with a random gap between bursts
    task automatic send_byte(logic [7:0] b, logic last);
        int unsigned gap;
        if (burst_left == 0 && !no_gaps) begin
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                u_in.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 30);
        end else if (burst_left > 0) begin
            burst_left--;
        end
        u_in.valid      <= 1'b1;
        u_in.code_byte  <= b;
        u_in.stream_end <= last;
        do @(posedge i_clk); while (!u_in.ready);
        random_sent++;
    endtask

    task automatic send_seq(t_bytes seq, bit end_on_last);
        int unsigned k;
        for (k = 0; k < seq.size(); k++)
            send_byte(seq[k], end_on_last && (k == seq.size() - 1));
    endtask

    // the wait comes before each check, so the monitor has noted the last transaction
    task automatic wait_all_results();
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    // data byte biased toward sign and range corners
    function automatic logic [7:0] random_byte();
        logic [7:0] v;
        if ($urandom_range(0, 3) == 0) begin
            case ($urandom_range(0, 3))
                0:       v = 8'h00;
                1:       v = 8'h7F;
                2:       v = 8'h80;
                default: v = 8'hFF;
            endcase
        end else begin
            v = 8'($urandom_range(0, 255));
        end
        return v;
    endfunction

    // well-formed MOV instruction with random content
    function automatic t_bytes random_mov();
        t_bytes      q;
        logic [7:0]  op;
        logic [7:0]  m;
        int unsigned n;
        int unsigned k;
        case ($urandom_range(0, 4))
            0:       op = {OP_RMREG_TOP, 2'($urandom_range(0, 3))};
            1:       op = {OP_IMMRM_TOP, 1'($urandom_range(0, 1))};
            2:       op = {OP_IMMREG_TOP, 4'($urandom_range(0, 15))};
            3:       op = {OP_MEMACC_TOP, 1'($urandom_range(0, 1))};
            default: op = {OP_ACCMEM_TOP, 1'($urandom_range(0, 1))};
        endcase
        q.push_back(op);
        case (movdec_scoreboard::form_of(op))
            FORM_RMREG, FORM_IMMRM: begin
                m = 8'($urandom_range(0, 255));
                q.push_back(m);
                n = movdec_scoreboard::disp_bytes(m);
                if (movdec_scoreboard::form_of(op) == FORM_IMMRM)
                    n = n + 1 + op[0];
            end
            FORM_IMMREG: n = 1 + op[3];
            default:     n = 2;
        endcase
        for (k = 0; k < n; k++)
            q.push_back(random_byte());
        return q;
    endfunction

    // stimulus
    initial begin
        t_bytes      seq;
        logic [7:0]  op;
        int unsigned cut;
        int unsigned k;
        bit          pressure_done;

        hold_req      = 1'b0;
        no_gaps       = 1'b0;
        burst_left    = 0;
        pressure_done = 1'b0;
        i_rst_n         <= 1'b0;
        u_in.valid      <= 1'b0;
        u_in.code_byte  <= 8'h00;
        u_in.stream_end <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: each form, direct address, byte and word corners
        send_seq('{8'h88, 8'hD8}, 1'b0);
        send_seq('{8'h8B, 8'h1E, 8'h34, 8'h12}, 1'b0);
        send_seq('{8'h89, 8'hC7}, 1'b0);
        send_seq('{8'hC7, 8'h06, 8'hFF, 8'hFF, 8'h01, 8'h80}, 1'b0);
        send_seq('{8'hC6, 8'h45, 8'h80, 8'h80}, 1'b0);
        send_seq('{8'hBF, 8'h34, 8'h12}, 1'b0);
        send_seq('{8'hA1, 8'h00, 8'h00}, 1'b0);
        // stream end on the last byte starts a fresh stream
        send_seq('{8'hA2, 8'hFF, 8'hFF}, 1'b1);

        // random well-formed streams
        random_sent = 0;
        while (random_sent < RANDOM_BYTES) begin
            if (!pressure_done && random_sent >= RANDOM_BYTES / 3) begin
                // back-to-back bytes against a held sink, then drain
                no_gaps  = 1'b1;
                hold_req = 1'b1;
                for (k = 0; k < PRESSURE_MOVS; k++)
                    send_seq(random_mov(), 1'b0);
                no_gaps = 1'b0;
                u_in.valid <= 1'b0;
                wait_all_results();
                pressure_done = 1'b1;
            end
            send_seq(random_mov(), ($urandom_range(0, 15) == 0));
        end

        // closing error: unknown opcode or stream cut inside an instruction
        if ($urandom_range(0, 1) == 0) begin
            do op = 8'($urandom_range(0, 255));
            while (movdec_scoreboard::form_of(op) != FORM_NONE);
            send_byte(op, 1'($urandom_range(0, 1)));
        end else begin
            seq = random_mov();
            cut = $urandom_range(1, seq.size() - 1);
            for (k = 0; k < cut; k++)
                send_byte(seq[k], k == cut - 1);
        end

        // bytes after the error are ignored
        for (k = 0; k < TAIL_BYTES; k++)
            send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        u_in.valid <= 1'b0;

        wait_all_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.error_count == 0 && sb.pending() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
